// ===== hdl/dmm_pkg.sv =====
package dmm_pkg;

  localparam int DIM = 64;

  localparam int MODE_W  = 2;
  localparam int ROW_W   = 6;
  localparam int COL_W   = 6;
  localparam int VALUE_W = 16;
  localparam int OCOL_W  = 6;
  localparam int ELEM_W  = 38;
  localparam int NUSED_W = 7;
  localparam int PROD_W  = 2 * VALUE_W;

  localparam int IDX_W   = $clog2(DIM);
  localparam int ADDR_W  = $clog2(DIM * DIM);
  localparam int DEPTH   = DIM * DIM;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [NUSED_W-1:0] NUSED_RESET = 7'd64;

  typedef enum logic [0:0] {
    REG_N_USED = 1'b0
  } reg_idx_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_WR_A = 2'd0,
    MODE_WR_B = 2'd1,
    MODE_REQ  = 2'd2
  } mode_t;

endpackage

// ===== hdl/dmm_if.sv =====
interface dmm_in_if;
  logic                                valid;
  logic                                ready;
  logic [dmm_pkg::MODE_W-1:0]          mode;
  logic [dmm_pkg::ROW_W-1:0]           row;
  logic [dmm_pkg::COL_W-1:0]           col;
  logic signed [dmm_pkg::VALUE_W-1:0]  value;

  modport source (output valid, mode, row, col, value, input ready);
  modport sink   (input valid, mode, row, col, value, output ready);
endinterface

interface dmm_out_if;
  logic                                valid;
  logic                                ready;
  logic [dmm_pkg::OCOL_W-1:0]          out_col;
  logic signed [dmm_pkg::ELEM_W-1:0]   element;
  logic                                last;
  logic                                all_equal;

  modport source (output valid, out_col, element, last, all_equal, input ready);
  modport sink   (input valid, out_col, element, last, all_equal, output ready);
endinterface

// ===== hdl/dmm_ram.sv =====
module dmm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/dense_matrix_multiply_top.sv =====
// write items are taken only while idle; a row request emits n elements, each after n reads
// of the two stores passed through the read, multiply and accumulate registers
// the pace of a full row is bounded by the single read port per store
// the next item is taken once the last element of the row sits in the output register
// reset clears control state, sets n_used to 64 and first_value to zero;
// store contents are not cleared
module dense_matrix_multiply_top (
  input  logic                         clk,
  input  logic                         rst,
  dmm_in_if.sink                       in_ch,
  dmm_out_if.source                    out_ch,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [dmm_pkg::PADDR_W-1:0]  paddr,
  input  logic [dmm_pkg::PDATA_W-1:0]  pwdata,
  output logic [dmm_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);
  import dmm_pkg::*;

  typedef enum logic [1:0] {
    IDLE,
    RUN,
    DRAIN
  } state_t;

  state_t state;

  logic [NUSED_W-1:0] n_used;
  logic [NUSED_W-1:0] n_eff;
  logic [IDX_W-1:0]   nm1;
  logic [IDX_W-1:0]   row_q;
  logic [IDX_W-1:0]   j_cnt;
  logic [IDX_W-1:0]   k_cnt;

  logic               v1;
  logic               v2;
  logic signed [PROD_W-1:0] prod;
  logic signed [ELEM_W-1:0] acc;
  logic signed [ELEM_W-1:0] first_value;
  logic               mismatch_seen;

  logic               out_valid;
  logic [OCOL_W-1:0]  out_col;
  logic signed [ELEM_W-1:0] element;
  logic               out_last;
  logic               all_equal;

  logic               in_fire;
  logic               wr_ok;
  logic [ADDR_W-1:0]  waddr;
  logic               we_a;
  logic               we_b;
  logic [ADDR_W-1:0]  raddr_a;
  logic [ADDR_W-1:0]  raddr_b;
  logic [VALUE_W-1:0] a_rdata;
  logic [VALUE_W-1:0] b_rdata;
  logic               issue;
  logic               emit;
  logic               first_elem;
  logic signed [ELEM_W-1:0] first_value_next;
  logic               mismatch_seen_next;
  logic               cfg_wr;

  // effective dimension, clamped to 1..DIM
  always_comb begin
    if (n_used == '0) begin
      n_eff = NUSED_W'(1);
    end else if (n_used > NUSED_W'(DIM)) begin
      n_eff = NUSED_W'(DIM);
    end else begin
      n_eff = n_used;
    end
  end

  assign in_ch.ready = (state == IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign wr_ok = (NUSED_W'(in_ch.row) < NUSED_W'(DIM)) && (NUSED_W'(in_ch.col) < NUSED_W'(DIM));
  assign waddr = ADDR_W'(ADDR_W'(in_ch.row) * ADDR_W'(DIM) + ADDR_W'(in_ch.col));
  assign we_a  = in_fire && wr_ok && (in_ch.mode == MODE_WR_A);
  assign we_b  = in_fire && wr_ok && (in_ch.mode == MODE_WR_B);

  // a walks along the row, b walks down column k
  assign raddr_a = ADDR_W'(ADDR_W'(row_q) * ADDR_W'(DIM) + ADDR_W'(j_cnt));
  assign raddr_b = ADDR_W'(ADDR_W'(j_cnt) * ADDR_W'(DIM) + ADDR_W'(k_cnt));
  assign issue   = (state == RUN);

  dmm_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_a_store (
    .clk   (clk),
    .we    (we_a),
    .waddr (waddr),
    .wdata (in_ch.value),
    .raddr (raddr_a),
    .rdata (a_rdata)
  );

  dmm_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_b_store (
    .clk   (clk),
    .we    (we_b),
    .waddr (waddr),
    .wdata (in_ch.value),
    .raddr (raddr_b),
    .rdata (b_rdata)
  );

  // element is final once the mac pipe is empty
  assign emit = (state == DRAIN) && !v1 && !v2 && (!out_valid || out_ch.ready);

  // row 0 element 0 defines the reference value
  assign first_elem = (row_q == '0) && (k_cnt == '0);
  always_comb begin
    if (first_elem) begin
      first_value_next   = acc;
      mismatch_seen_next = 1'b0;
    end else begin
      first_value_next   = first_value;
      mismatch_seen_next = mismatch_seen || (acc != first_value);
    end
  end

  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_N_USED);
  assign pready = 1'b1;
  always_comb begin
    if (paddr[2] == REG_N_USED) begin
      prdata = PDATA_W'(n_used);
    end else begin
      prdata = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n_used <= NUSED_RESET;
    end else if (cfg_wr) begin
      n_used <= pwdata[NUSED_W-1:0];
    end
  end

  // mac datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= issue;
      v2 <= v1;
    end
    if (v1) begin
      prod <= $signed(a_rdata) * $signed(b_rdata);
    end
    if (issue && j_cnt == '0) begin
      acc <= '0;
    end else if (v2) begin
      acc <= acc + ELEM_W'(prod);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= IDLE;
      out_valid     <= 1'b0;
      first_value   <= '0;
      mismatch_seen <= 1'b0;
      j_cnt         <= '0;
      k_cnt         <= '0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (in_fire && in_ch.mode == MODE_REQ && NUSED_W'(in_ch.row) < n_eff) begin
            row_q <= IDX_W'(in_ch.row);
            nm1   <= IDX_W'(n_eff - NUSED_W'(1));
            j_cnt <= '0;
            k_cnt <= '0;
            state <= RUN;
          end
        end
        RUN: begin
          if (j_cnt == nm1) begin
            state <= DRAIN;
          end else begin
            j_cnt <= j_cnt + IDX_W'(1);
          end
        end
        DRAIN: begin
          if (emit) begin
            out_col       <= OCOL_W'(k_cnt);
            element       <= acc;
            out_last      <= (k_cnt == nm1);
            all_equal     <= !mismatch_seen_next;
            first_value   <= first_value_next;
            mismatch_seen <= mismatch_seen_next;
            j_cnt         <= '0;
            if (k_cnt == nm1) begin
              state <= IDLE;
            end else begin
              k_cnt <= k_cnt + IDX_W'(1);
              state <= RUN;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  assign out_ch.valid     = out_valid;
  assign out_ch.out_col   = out_col;
  assign out_ch.element   = element;
  assign out_ch.last      = out_last;
  assign out_ch.all_equal = all_equal;

endmodule
